>>> src/upd_pkg.sv
// upd_pkg: shared types, constants and helpers of the url percent decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package upd_pkg;

    // percent character that opens an escape
    localparam logic [7:0] PCT_CHAR = 8'h25;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // decode phase codes
    localparam logic [1:0] PH_PLAIN  = 2'd0;
    localparam logic [1:0] PH_PCT    = 2'd1;
    localparam logic [1:0] PH_DIGIT1 = 2'd2;

    // one queued word: pair means emit '%' first, then data
    typedef struct packed {
        logic       pair;
        logic [7:0] data;
        logic       last;
    } upd_entry_t;

    // hex digit value, any other byte counts as zero
    function automatic logic [3:0] digit_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b[3:0];
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = 4'(b[2:0] + 3'd1) + 4'd8;
        end
        return v;
    endfunction

endpackage

>>> src/upd_front.sv
// upd_front: accepts input words, tracks the decode phase, builds queue entries
// depends on upd_pkg
`timescale 1ns / 1ps

module upd_front
    import upd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       q_ready,
    output logic       q_push,
    output upd_entry_t q_entry
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    // classify the word against the current phase
    always_comb begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        q_push           = 1'b0;
        q_entry.pair     = 1'b0;
        q_entry.data     = s_in_byte;
        q_entry.last     = s_in_last;
        if (accept) begin
            unique case (phase_reg)
                PH_PCT: begin
                    if (s_in_last) begin
                        q_push       = 1'b1;
                        q_entry.pair = 1'b1;
                        phase_next   = PH_PLAIN;
                    end else begin
                        high_nibble_next = digit_value(s_in_byte);
                        phase_next       = PH_DIGIT1;
                    end
                end
                PH_DIGIT1: begin
                    q_push       = 1'b1;
                    q_entry.data = {high_nibble_reg, digit_value(s_in_byte)};
                    phase_next   = PH_PLAIN;
                end
                default: begin
                    if (s_in_byte == PCT_CHAR && !s_in_last) begin
                        phase_next = PH_PCT;
                    end else begin
                        q_push     = 1'b1;
                        phase_next = PH_PLAIN;
                    end
                end
            endcase
        end
    end

    // phase state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PLAIN;
            high_nibble_reg <= 4'd0;
        end else begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
        end
    end

endmodule

>>> src/upd_queue.sv
// upd_queue: small register queue of decoded entries between front and back
// depends on upd_pkg
`timescale 1ns / 1ps

module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  upd_entry_t push_entry,
    output logic       push_ready,
    input  logic       pop,
    output logic       head_valid,
    output upd_entry_t head_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    upd_entry_t    slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/upd_back.sv
// upd_back: drains queue entries into the registered output word stream
// depends on upd_pkg
`timescale 1ns / 1ps

module upd_back
    import upd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  upd_entry_t head_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic [7:0] second_byte_reg, second_byte_next;
    logic       second_last_reg, second_last_next;
    logic       load_ok;

    assign load_ok = !valid_reg || m_ready;

    // output slot refill: pending second word first, then the queue head
    always_comb begin
        valid_next       = valid_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        second_next      = second_reg;
        second_byte_next = second_byte_reg;
        second_last_next = second_last_reg;
        pop              = 1'b0;
        if (load_ok) begin
            priority if (second_reg) begin
                valid_next  = 1'b1;
                byte_next   = second_byte_reg;
                last_next   = second_last_reg;
                second_next = 1'b0;
            end else if (head_valid) begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (head_entry.pair) begin
                    byte_next        = PCT_CHAR;
                    last_next        = 1'b0;
                    second_next      = 1'b1;
                    second_byte_next = head_entry.data;
                    second_last_next = head_entry.last;
                end else begin
                    byte_next = head_entry.data;
                    last_next = head_entry.last;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        byte_reg        <= byte_next;
        last_reg        <= last_next;
        second_byte_reg <= second_byte_next;
        second_last_reg <= second_last_next;
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_last = last_reg;

endmodule

>>> src/url_percent_decoder_core.sv
// url_percent_decoder_core: top level of the streaming url percent decoder
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_in_byte[7:0], s_in_last
//   m_       out        m_valid/m_ready    m_out_byte[7:0], m_out_last
//
// one input word per cycle while the entry queue has room; a decoded word reaches
// the output through the entry queue and then the output register.
// a percent followed by one final byte yields two output words, the percent
// and then the byte, one after the other from the output register. synchronous
// active-low reset clears the decode phase, the queue and the output register.
// s_ready drops only when the queue is full, so each side stalls on its own.
`timescale 1ns / 1ps

module url_percent_decoder_core
    import upd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic       q_ready;
    logic       q_push;
    upd_entry_t q_entry;
    logic       q_pop;
    logic       q_head_valid;
    upd_entry_t q_head;

    // front: phase tracking and classification
    upd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // entry queue
    upd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    // back: output word sequencing
    upd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

>>> verif/url_percent_decoder_core_test.sv
// url_percent_decoder_core_test: self-checking bench for the streaming url percent decoder
// depends on upd_pkg and url_percent_decoder_core; a local predictor checks every output word
`timescale 1ns / 1ps

module url_percent_decoder_core_test;
    import upd_pkg::*;

    typedef logic [7:0] char_q_t[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_word_t;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    // decoder state mirrored by the predictor
    logic [1:0] pred_phase;
    logic [3:0] pred_high;

    decoded_word_t decoded_q[$];
    int            send_idle_pct;
    int            recv_stall_pct;
    int            words_sent;
    int            error_count;
    int            quiet_cycles;

    url_percent_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_out_last(m_out_last)
    );

    always #10 aclk = ~aclk;

    // value of a hex character, anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - "0");
        end
        if (c >= "A" && c <= "F") begin
            return 4'(c - "A" + 10);
        end
        if (c >= "a" && c <= "f") begin
            return 4'(c - "a" + 10);
        end
        return 4'd0;
    endfunction

    // queue the output words one accepted input word produces
    function automatic void predict_decode(input logic [7:0] c, input logic last);
        unique case (pred_phase)
            PH_PCT: begin
                if (last) begin
                    decoded_q.push_back('{data: PCT_CHAR, last: 1'b0});
                    decoded_q.push_back('{data: c, last: 1'b1});
                    pred_phase = PH_PLAIN;
                end else begin
                    pred_high  = hex_nibble(c);
                    pred_phase = PH_DIGIT1;
                end
            end
            PH_DIGIT1: begin
                decoded_q.push_back('{data: {pred_high, hex_nibble(c)}, last: last});
                pred_phase = PH_PLAIN;
            end
            default: begin
                if (c == PCT_CHAR && !last) begin
                    pred_phase = PH_PCT;
                end else begin
                    decoded_q.push_back('{data: c, last: last});
                    pred_phase = PH_PLAIN;
                end
            end
        endcase
    endfunction

    // random hex digit in either case, sometimes any byte at all
    function automatic logic [7:0] random_digit();
        unique case ($urandom_range(0, 3))
            0: return 8'($urandom_range("0", "9"));
            1: return 8'($urandom_range("A", "F"));
            2: return 8'($urandom_range("a", "f"));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= c;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_decode(c, last);
        words_sent++;
    endtask

    // send one string, flag on its final character
    task automatic send_string(input char_q_t str);
        foreach (str[i]) begin
            send_word(str[i], i == str.size() - 1);
        end
    endtask

    // plain bytes, full escapes and escapes with odd digits
    task automatic test_directed_escapes();
        send_string('{8'h00, 8'h00});
        send_string('{8'hFF});
        send_string('{PCT_CHAR, "4", "1"});
        send_string('{PCT_CHAR, "f", "F"});
        send_string('{PCT_CHAR, "g", "Z"});
        send_string('{PCT_CHAR, PCT_CHAR, PCT_CHAR});
        send_string('{PCT_CHAR, "9", "a", "x"});
    endtask

    // escapes cut short by the end of the string
    task automatic test_truncated_escapes();
        send_string('{PCT_CHAR});
        send_string('{PCT_CHAR, "7"});
        send_string('{PCT_CHAR, PCT_CHAR});
        send_string('{"q", PCT_CHAR, 8'h00});
    endtask

    // mostly well-formed strings with random content, tails cut now and then
    task automatic test_random_strings(input int count);
        char_q_t str;
        int      first;
        int      tokens;
        int      kind;
        first = words_sent;
        while (words_sent - first < count) begin
            str.delete();
            tokens = $urandom_range(1, 6);
            for (int t = 0; t < tokens; t++) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    str.push_back(PCT_CHAR);
                    str.push_back(random_digit());
                    str.push_back(random_digit());
                end else if (kind < 9) begin
                    str.push_back(8'($urandom_range(0, 255)));
                end else begin
                    str.push_back(PCT_CHAR);
                end
            end
            if (str.size() > 1 && $urandom_range(0, 3) == 0) begin
                str.pop_back();
            end
            if (str.size() > 1 && $urandom_range(0, 3) == 0) begin
                str.pop_back();
            end
            send_string(str);
        end
    endtask

    // receiver stalls at the current rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each output word with the oldest prediction
    always @(posedge aclk) begin
        decoded_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected word: byte %02h last %0b", m_out_byte, m_out_last);
                end
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.data || m_out_last !== want.last) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, m_out_byte, m_out_last);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("url_percent_decoder_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pred_phase     = PH_PLAIN;
        pred_high      = 4'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_escapes();
        test_truncated_escapes();

        // no idling
        test_random_strings(400);
        // sender mostly idle
        send_idle_pct = 81;
        test_random_strings(400);
        // receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        test_random_strings(400);
        // both sides idling
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        test_random_strings(400);

        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("url_percent_decoder_core test passed");
        end else begin
            $display("url_percent_decoder_core test failed");
        end
        $finish;
    end

endmodule
